[design/qvr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Shared widths, constants and payload types of the rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Field width and fraction bits of the quaternion components.
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 15;

  // Product of two fields.
  localparam int PROD_W = 2 * DATA_WIDTH;
  // First product q*v: sum of three field products, kept exact.
  localparam int P_W    = 2 * DATA_WIDTH + 1;
  // Second product p*conj(q): sum of four wide products plus rounding.
  localparam int S_W    = 3 * DATA_WIDTH + 4;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;
    logic                         saturated;
  } qvr_out_t;

  // Quaternion carried alongside the partial results.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] w;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] y;
    logic signed [DATA_WIDTH-1:0] z;
  } qvr_quat_t;

  // Intermediate quaternion p = q * (0, v), FRAC_BITS fraction bits.
  typedef struct packed {
    logic signed [P_W-1:0] w;
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
  } qvr_pquat_t;

  // Rounded but not yet shifted vector part of p * conj(q).
  typedef struct packed {
    logic signed [S_W-1:0] x;
    logic signed [S_W-1:0] y;
    logic signed [S_W-1:0] z;
  } qvr_svec_t;

endpackage

[design/qvr_qv_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First Hamilton product
// Two register stages: twelve field products, then the four sums of p = q*v.
// ----------------------------------------------------------------------------
module qvr_qv_mult (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  qvr_pkg::qvr_in_t   item_i,
  output logic               valid_o,
  output qvr_pkg::qvr_pquat_t p_o,
  output qvr_pkg::qvr_quat_t q_o
);
  import qvr_pkg::*;

  logic signed [PROD_W-1:0] prod_d [12];
  logic signed [PROD_W-1:0] prod_q [12];
  qvr_quat_t                q1_q;
  qvr_quat_t                q2_q;
  qvr_pquat_t               p_d;
  qvr_pquat_t               p_q;
  logic                     v1_q;
  logic                     v2_q;

  always_comb begin
    // Scalar part terms.
    prod_d[0]  = item_i.quat_x * item_i.vec_x;
    prod_d[1]  = item_i.quat_y * item_i.vec_y;
    prod_d[2]  = item_i.quat_z * item_i.vec_z;
    // i terms.
    prod_d[3]  = item_i.quat_w * item_i.vec_x;
    prod_d[4]  = item_i.quat_y * item_i.vec_z;
    prod_d[5]  = item_i.quat_z * item_i.vec_y;
    // j terms.
    prod_d[6]  = item_i.quat_w * item_i.vec_y;
    prod_d[7]  = item_i.quat_x * item_i.vec_z;
    prod_d[8]  = item_i.quat_z * item_i.vec_x;
    // k terms.
    prod_d[9]  = item_i.quat_w * item_i.vec_z;
    prod_d[10] = item_i.quat_x * item_i.vec_y;
    prod_d[11] = item_i.quat_y * item_i.vec_x;
  end

  always_comb begin
    p_d.w = -P_W'(prod_q[0]) - P_W'(prod_q[1]) - P_W'(prod_q[2]);
    p_d.x =  P_W'(prod_q[3]) + P_W'(prod_q[4]) - P_W'(prod_q[5]);
    p_d.y =  P_W'(prod_q[6]) - P_W'(prod_q[7]) + P_W'(prod_q[8]);
    p_d.z =  P_W'(prod_q[9]) + P_W'(prod_q[10]) - P_W'(prod_q[11]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    q1_q   <= '{w: item_i.quat_w, x: item_i.quat_x, y: item_i.quat_y, z: item_i.quat_z};
    p_q    <= p_d;
    q2_q   <= q1_q;
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign q_o     = q2_q;

endmodule

[design/qvr_pq_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second Hamilton product
// Two register stages: twelve wide products, then the rounded vector sums.
// ----------------------------------------------------------------------------
module qvr_pq_mult (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  qvr_pkg::qvr_pquat_t p_i,
  input  qvr_pkg::qvr_quat_t  q_i,
  output logic                valid_o,
  output qvr_pkg::qvr_svec_t  s_o
);
  import qvr_pkg::*;

  // Half of one output unit, added before the final right shift.
  localparam logic signed [S_W-1:0] RND = S_W'(64'd1 << (2 * FRAC_BITS - 1));

  logic signed [S_W-1:0] prod_d [12];
  logic signed [S_W-1:0] prod_q [12];
  qvr_svec_t             s_d;
  qvr_svec_t             s_q;
  logic                  v1_q;
  logic                  v2_q;

  always_comb begin
    // x terms.
    prod_d[0]  = p_i.w * q_i.x;
    prod_d[1]  = p_i.x * q_i.w;
    prod_d[2]  = p_i.y * q_i.z;
    prod_d[3]  = p_i.z * q_i.y;
    // y terms.
    prod_d[4]  = p_i.w * q_i.y;
    prod_d[5]  = p_i.x * q_i.z;
    prod_d[6]  = p_i.y * q_i.w;
    prod_d[7]  = p_i.z * q_i.x;
    // z terms.
    prod_d[8]  = p_i.w * q_i.z;
    prod_d[9]  = p_i.x * q_i.y;
    prod_d[10] = p_i.y * q_i.x;
    prod_d[11] = p_i.z * q_i.w;
  end

  always_comb begin
    s_d.x = RND - prod_q[0] + prod_q[1] - prod_q[2]  + prod_q[3];
    s_d.y = RND - prod_q[4] + prod_q[5] + prod_q[6]  - prod_q[7];
    s_d.z = RND - prod_q[8] - prod_q[9] + prod_q[10] + prod_q[11];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    s_q    <= s_d;
  end

  assign valid_o = v2_q;
  assign s_o     = s_q;

endmodule

[design/qvr_round_sat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output scaling and saturation
// Drops the fraction bits, clips each component and registers the result.
// ----------------------------------------------------------------------------
module qvr_round_sat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  qvr_pkg::qvr_svec_t s_i,
  output logic               valid_o,
  output qvr_pkg::qvr_out_t  result_o
);
  import qvr_pkg::*;

  localparam logic signed [S_W-1:0] SAT_HI = S_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [S_W-1:0] SAT_LO = -SAT_HI - S_W'(1);

  // Returns the clip flag above the clipped component.
  function automatic logic [DATA_WIDTH:0] scale_clip(input logic signed [S_W-1:0] s);
    logic signed [S_W-1:0] r;
    r = s >>> (2 * FRAC_BITS);
    if (r > SAT_HI) begin
      scale_clip = {1'b1, SAT_HI[DATA_WIDTH-1:0]};
    end else if (r < SAT_LO) begin
      scale_clip = {1'b1, SAT_LO[DATA_WIDTH-1:0]};
    end else begin
      scale_clip = {1'b0, r[DATA_WIDTH-1:0]};
    end
  endfunction

  logic [DATA_WIDTH:0] cx;
  logic [DATA_WIDTH:0] cy;
  logic [DATA_WIDTH:0] cz;
  qvr_out_t            res_d;
  qvr_out_t            res_q;
  logic                valid_q;

  always_comb begin
    cx              = scale_clip(s_i.x);
    cy              = scale_clip(s_i.y);
    cz              = scale_clip(s_i.z);
    res_d.rot_x     = cx[DATA_WIDTH-1:0];
    res_d.rot_y     = cy[DATA_WIDTH-1:0];
    res_d.rot_z     = cz[DATA_WIDTH-1:0];
    res_d.saturated = cx[DATA_WIDTH] | cy[DATA_WIDTH] | cz[DATA_WIDTH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

[design/quaternion_vector_rotate_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a 3-D vector by a Q1.15 quaternion, computing q * v * conj(q).
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle: busy is never raised, so an
// item is accepted at every rising edge where start is high. Each item yields
// exactly one result, shown on result_o with valid_o high for one cycle. The
// item passes through five register stages in order: the twelve products of
// q*v, their sums, the twelve wide products of p*conj(q), their rounded sums,
// and the final scaling and clipping. Results leave in the order the items
// came in. The receiver cannot stall the block and must take each result in
// its cycle. A quaternion that is not of unit length scales the vector by its
// squared norm; any component that falls outside the 16-bit range is clipped
// and the saturated flag of that result is set. Rounding is half toward plus
// infinity. There is no state between items and no configuration.
module quaternion_vector_rotate_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qvr_pkg::qvr_in_t  item_i,
  output logic              valid_o,
  output qvr_pkg::qvr_out_t result_o
);
  import qvr_pkg::*;

  // Accept an item whenever start is high; the pipeline never backs up.
  logic       accept;
  logic       qv_valid;
  qvr_pquat_t qv_p;
  qvr_quat_t  qv_q;
  logic       pq_valid;
  qvr_svec_t  pq_s;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Stages one and two: p = q * (0, v), kept exact.
  qvr_qv_mult u_qv_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .valid_o (qv_valid),
    .p_o     (qv_p),
    .q_o     (qv_q)
  );

  // Stages three and four: vector part of p * conj(q), plus the rounding half.
  qvr_pq_mult u_pq_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qv_valid),
    .p_i     (qv_p),
    .q_i     (qv_q),
    .valid_o (pq_valid),
    .s_o     (pq_s)
  );

  // Stage five: drop the fraction bits, clip, and register the result.
  qvr_round_sat u_round_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pq_valid),
    .s_i      (pq_s),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Every result comes from an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 5))
    else $error("result without a matching accepted item");

  // Every item accepted while out of reset, with reset held off meanwhile, yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(accept, 5) && $past(rst_ni, 5) && $past(rst_ni, 4) && $past(rst_ni, 3) &&
     $past(rst_ni, 2) && $past(rst_ni, 1)) |-> valid_o)
    else $error("accepted item produced no result");

  // A clipped result must have at least one component at a range limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.saturated) |->
      (result_o.rot_x == OUT_MAX || result_o.rot_x == OUT_MIN ||
       result_o.rot_y == OUT_MAX || result_o.rot_y == OUT_MIN ||
       result_o.rot_z == OUT_MAX || result_o.rot_z == OUT_MIN))
    else $error("saturated flag set with no component at a limit");

endmodule

[tb/tb_quaternion_vector_rotate_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation testbench
// Drives directed and random quaternion/vector items into the rotation
// pipeline and checks each rotated vector against a built-in predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_top;
  import qvr_pkg::*;

  // The pipeline is five register stages deep. The tail wait adds margin so
  // that a stray trailing result still shows up before the verdict.
  localparam int PIPE_LATENCY = 5;
  localparam int TAIL_CYCLES  = PIPE_LATENCY + 4;
  // The slowest correct run never goes longer than one sender gap plus the
  // time to empty the pipeline without an accepted item or a result.
  localparam int IDLE_LIMIT   = 200;
  localparam int RANDOM_ITEMS = 800;

  // Ways of drawing one 16-bit field in the random part.
  typedef enum int {
    FIELD_FULL,
    FIELD_CORNER,
    FIELD_SMALL,
    FIELD_HALF
  } field_style_e;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  qvr_in_t  item_i;
  logic     valid_o;
  qvr_out_t result_o;

  // Rotated vectors predicted for accepted items, oldest first.
  qvr_out_t rotated_q[$];
  int       err_count;
  int       idle_cycles;
  // While set, the sender issues items back to back with no gaps.
  bit       burst_mode;

  quaternion_vector_rotate_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Rounds a sum with 2*FRAC_BITS fraction bits to an integer, half toward
  // plus infinity, and clips it to the field range. The clip flag is sticky
  // across the three components of one vector.
  function automatic logic signed [DATA_WIDTH-1:0] round_and_clip(input longint sum,
                                                                  inout bit clipped);
    longint rounded;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    rounded = (sum + (longint'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    if (rounded > hi) begin
      rounded = hi;
      clipped = 1'b1;
    end else if (rounded < lo) begin
      rounded = lo;
      clipped = 1'b1;
    end
    return rounded[DATA_WIDTH-1:0];
  endfunction

  // Computes q * (0, v) * conj(q) with exact 64-bit intermediates and keeps
  // the vector part. Every component reads the original operand values.
  function automatic qvr_out_t rotate_vector(input qvr_in_t it);
    longint qw, qx, qy, qz, vx, vy, vz;
    longint pw, px, py, pz;
    longint sx, sy, sz;
    bit clipped;
    qvr_out_t res;
    qw = longint'(it.quat_w);
    qx = longint'(it.quat_x);
    qy = longint'(it.quat_y);
    qz = longint'(it.quat_z);
    vx = longint'(it.vec_x);
    vy = longint'(it.vec_y);
    vz = longint'(it.vec_z);
    clipped = 1'b0;
    pw = -(qx * vx) - qy * vy - qz * vz;
    px = qw * vx + qy * vz - qz * vy;
    py = qw * vy - qx * vz + qz * vx;
    pz = qw * vz + qx * vy - qy * vx;
    sx = -(pw * qx) + px * qw - py * qz + pz * qy;
    sy = -(pw * qy) + px * qz + py * qw - pz * qx;
    sz = -(pw * qz) - px * qy + py * qx + pz * qw;
    res.rot_x     = round_and_clip(sx, clipped);
    res.rot_y     = round_and_clip(sy, clipped);
    res.rot_z     = round_and_clip(sz, clipped);
    res.saturated = clipped;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Prediction, checking and the watchdog share one clocked process, so the
  // store of expected vectors is only ever changed from one place. All
  // inputs are driven with nonblocking assignments, so the values read here
  // are the ones the block sees at this edge.
  always @(posedge clk_i) begin
    qvr_out_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        rotated_q.push_back(rotate_vector(item_i));
        moved = 1'b1;
      end
      if (valid_o) begin
        moved = 1'b1;
        if (rotated_q.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: x=%0d y=%0d z=%0d",
                                    result_o.rot_x, result_o.rot_y, result_o.rot_z));
        end else begin
          want = rotated_q.pop_front();
          if (result_o.rot_x !== want.rot_x)
            report_mismatch($sformatf("rot_x got %0d want %0d",
                                      result_o.rot_x, want.rot_x));
          if (result_o.rot_y !== want.rot_y)
            report_mismatch($sformatf("rot_y got %0d want %0d",
                                      result_o.rot_y, want.rot_y));
          if (result_o.rot_z !== want.rot_z)
            report_mismatch($sformatf("rot_z got %0d want %0d",
                                      result_o.rot_z, want.rot_z));
          if (result_o.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %b want %b",
                                      result_o.saturated, want.saturated));
        end
      end
    end
    // Nothing moving for this long means the pipeline has hung.
    if (moved) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("quaternion_vector_rotate_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one item. The task starts and ends at a rising edge. A gap of random
  // length comes first, unless a burst is running; with no gap, start simply
  // stays high from the previous item.
  task automatic send_item(input qvr_in_t it);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Holds the sender off until every pending rotation has come back.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk_i);
    while (rotated_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_field(input field_style_e style);
    logic signed [DATA_WIDTH-1:0] val;
    case (style)
      FIELD_CORNER: begin
        case ($urandom_range(0, 6))
          0: val = -16'sd32768;
          1: val = 16'sd32767;
          2: val = 16'sd0;
          3: val = 16'sd1;
          4: val = -16'sd1;
          5: val = -16'sd32767;
          default: val = 16'sd16384;
        endcase
      end
      FIELD_SMALL: val = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      FIELD_HALF:  val = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
      default:     val = 16'($urandom);
    endcase
    return val;
  endfunction

  // Scalar quaternions at both ends of the range, where -1 returns the vector
  // exactly, including its most negative values; then a zero quaternion and a zero vector.
  task automatic test_identity();
    send_item(qvr_in_t'{16'sd32767, 16'sd0, 16'sd0, 16'sd0,
                        16'sd32767, -16'sd32768, 16'sd1});
    send_item(qvr_in_t'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0,
                        16'sd32767, -16'sd32768, 16'sd1});
    send_item(qvr_in_t'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0,
                        -16'sd1, 16'sd0, -16'sd32768});
    send_item(qvr_in_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        16'sd32767, 16'sd32767, 16'sd32767});
    send_item(qvr_in_t'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                        16'sd0, 16'sd0, 16'sd0});
  endtask

  // Quarter and half turns about each axis, so that every term of both
  // Hamilton products is exercised with a nonzero operand.
  task automatic test_axis_turns();
    send_item(qvr_in_t'{16'sd23170, 16'sd0, 16'sd0, 16'sd23170,
                        16'sd1000, 16'sd2000, 16'sd3000});
    send_item(qvr_in_t'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0,
                        16'sd1000, 16'sd2000, 16'sd3000});
    send_item(qvr_in_t'{16'sd23170, 16'sd0, -16'sd23170, 16'sd0,
                        -16'sd1000, 16'sd2000, -16'sd3000});
    send_item(qvr_in_t'{16'sd0, 16'sd32767, 16'sd0, 16'sd0,
                        16'sd12345, -16'sd54, 16'sd777});
    send_item(qvr_in_t'{16'sd0, 16'sd0, -16'sd32768, 16'sd0,
                        16'sd12345, -16'sd54, 16'sd777});
    send_item(qvr_in_t'{16'sd0, 16'sd0, 16'sd0, -16'sd32768,
                        -16'sd32768, 16'sd32767, 16'sd5});
  endtask

  // Rounding ties: a quarter-scale quaternion maps 2, -2 and -6 onto half
  // values, which must round toward plus infinity.
  task automatic test_rounding_ties();
    send_item(qvr_in_t'{16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                        16'sd2, -16'sd2, -16'sd6});
    send_item(qvr_in_t'{-16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                        -16'sd10, 16'sd6, 16'sd1});
    send_item(qvr_in_t'{16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                        16'sd2, -16'sd2, -16'sd6});
  endtask

  // Non-unit quaternions scale the vector by the squared norm and drive the
  // components past the 16-bit range in both directions.
  task automatic test_saturation();
    send_item(qvr_in_t'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                        16'sd32767, 16'sd32767, 16'sd32767});
    send_item(qvr_in_t'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                        -16'sd32768, -16'sd32768, -16'sd32768});
    send_item(qvr_in_t'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                        -16'sd32768, 16'sd32767, -16'sd32768});
    send_item(qvr_in_t'{16'sd32767, 16'sd0, 16'sd0, 16'sd32767,
                        16'sd20000, 16'sd0, 16'sd0});
    send_item(qvr_in_t'{16'sd32767, 16'sd0, 16'sd0, 16'sd32767,
                        16'sd0, 16'sd0, -16'sd20000});
  endtask

  // Random items. Most draw each quaternion field from the half range, with a
  // random vector; the rest draw every field from the full range or from mixed
  // styles, which mostly saturates. Bursts with no gaps come and go, and once
  // midway the sender waits for a full drain.
  task automatic test_random();
    qvr_in_t it;
    field_style_e q_style;
    field_style_e v_style;
    int kind;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0)
        burst_mode = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2)
        drain_pipeline();
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        q_style = FIELD_HALF;
        v_style = ($urandom_range(0, 3) == 0) ? FIELD_CORNER : FIELD_FULL;
      end else if (kind < 8) begin
        q_style = FIELD_FULL;
        v_style = FIELD_FULL;
      end else begin
        q_style = field_style_e'($urandom_range(0, 3));
        v_style = field_style_e'($urandom_range(0, 3));
      end
      it.quat_w = pick_field(q_style);
      it.quat_x = pick_field(q_style);
      it.quat_y = pick_field(q_style);
      it.quat_z = pick_field(q_style);
      it.vec_x  = pick_field(v_style);
      it.vec_y  = pick_field(v_style);
      it.vec_z  = pick_field(v_style);
      send_item(it);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    err_count   = 0;
    idle_cycles = 0;
    burst_mode  = 1'b0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity();
    test_axis_turns();
    test_rounding_ties();
    test_saturation();
    test_random();

    // Let the pipeline empty, then keep watching for stray results before the verdict.
    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (rotated_q.size() != 0)
      report_mismatch($sformatf("%0d items never produced a result", rotated_q.size()));

    if (err_count == 0) begin
      $display("quaternion_vector_rotate_top regression: pass");
    end else begin
      $display("quaternion_vector_rotate_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/qvr_pkg.sv
design/qvr_qv_mult.sv
design/qvr_pq_mult.sv
design/qvr_round_sat.sv
design/quaternion_vector_rotate_top.sv
tb/tb_quaternion_vector_rotate_top.sv
